// ===== rtl/sip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sip_pkg;

  // Coordinate width and the widths that follow from it.
  localparam int CoordWidth = 12;
  localparam int DW   = CoordWidth + 1;  // signed coordinate difference
  localparam int PW   = 2 * DW;          // product of two differences
  localparam int CPW  = PW + 1;          // cross product
  localparam int DENW = CPW + 1;         // denominator is1 + is2
  localparam int NW   = DW + CPW;        // delta * is1
  localparam int UW   = NW + 11;         // scaled numerator and divider working width
  localparam int QW   = CoordWidth + 1;  // quotient, at most 2^CoordWidth on a crossing
  localparam int SW   = CoordWidth + 2;  // signed sum before clamping

  // Rounding scales: one half for a non-negative offset, 999/1000 for a negative one.
  localparam logic [UW-1:0] ScaleNeg = UW'(1000);

  typedef logic [CoordWidth-1:0] coord_t;

  // Geometry results handed from the cross-product stages to the scaling stages.
  typedef struct packed {
    logic                   hit;
    logic signed [DENW-1:0] den;
    logic signed [CPW-1:0]  is1;
    logic signed [DW-1:0]   adx;
    logic signed [DW-1:0]   ady;
    coord_t                 asx;
    coord_t                 asy;
  } geom_t;

  // One lane of the restoring divider.
  typedef struct packed {
    logic          neg;
    logic [UW-1:0] rem;
    logic [UW-1:0] dvs;
    logic [QW-1:0] quo;
  } lane_t;

  // Beat travelling through the divider.
  typedef struct packed {
    logic   hit;
    coord_t asx;
    coord_t asy;
    lane_t  x;
    lane_t  y;
  } div_t;

endpackage
`default_nettype wire

// ===== rtl/sip_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Segment pair channel.
interface sip_in_if;
  logic            valid;
  logic            ready;
  sip_pkg::coord_t a_start_x;
  sip_pkg::coord_t a_start_y;
  sip_pkg::coord_t a_end_x;
  sip_pkg::coord_t a_end_y;
  sip_pkg::coord_t b_start_x;
  sip_pkg::coord_t b_start_y;
  sip_pkg::coord_t b_end_x;
  sip_pkg::coord_t b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
    output b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
    input  b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

// Crossing result channel.
interface sip_out_if;
  logic            valid;
  logic            ready;
  logic            crosses;
  sip_pkg::coord_t cross_x;
  sip_pkg::coord_t cross_y;

  modport source (output valid, crosses, cross_x, cross_y, input ready);
  modport sink (input valid, crosses, cross_x, cross_y, output ready);
endinterface
`default_nettype wire

// ===== rtl/sip_geom.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sip_geom (
  input  wire logic          clk,
  input  wire logic          rst,
  sip_in_if.sink             seg,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sip_pkg::geom_t     out_data
);

  logic st1_valid, st2_valid, st3_valid;
  logic rdy1, rdy2, rdy3;

  // Each stage moves on when it is empty or the next one takes its beat.
  assign rdy3      = !st3_valid || out_ready;
  assign rdy2      = !st2_valid || rdy3;
  assign rdy1      = !st1_valid || rdy2;
  assign seg.ready = rdy1;
  assign out_valid = st3_valid;

  // Coordinate differences.
  logic signed [sip_pkg::DW-1:0] adx, ady, bdx, bdy;
  logic signed [sip_pkg::DW-1:0] d_bsx_asx, d_bsy_asy, d_bex_asx, d_bey_asy;
  logic signed [sip_pkg::DW-1:0] d_aex_bsx, d_aey_bsy;

  assign adx       = $signed({1'b0, seg.a_end_x})   - $signed({1'b0, seg.a_start_x});
  assign ady       = $signed({1'b0, seg.a_end_y})   - $signed({1'b0, seg.a_start_y});
  assign bdx       = $signed({1'b0, seg.b_end_x})   - $signed({1'b0, seg.b_start_x});
  assign bdy       = $signed({1'b0, seg.b_end_y})   - $signed({1'b0, seg.b_start_y});
  assign d_bsx_asx = $signed({1'b0, seg.b_start_x}) - $signed({1'b0, seg.a_start_x});
  assign d_bsy_asy = $signed({1'b0, seg.b_start_y}) - $signed({1'b0, seg.a_start_y});
  assign d_bex_asx = $signed({1'b0, seg.b_end_x})   - $signed({1'b0, seg.a_start_x});
  assign d_bey_asy = $signed({1'b0, seg.b_end_y})   - $signed({1'b0, seg.a_start_y});
  assign d_aex_bsx = $signed({1'b0, seg.a_end_x})   - $signed({1'b0, seg.b_start_x});
  assign d_aey_bsy = $signed({1'b0, seg.a_end_y})   - $signed({1'b0, seg.b_start_y});

  // Stage one: the eight products of the four cross products.
  logic signed [sip_pkg::PW-1:0] prod [8];
  logic signed [sip_pkg::DW-1:0] s1_adx, s1_ady;
  sip_pkg::coord_t               s1_asx, s1_asy;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
    end else if (rdy1) begin
      st1_valid <= seg.valid;
    end
    if (rdy1) begin
      prod[0] <= d_bsx_asx * ady;
      prod[1] <= d_bsy_asy * adx;
      prod[2] <= d_bex_asx * ady;
      prod[3] <= d_bey_asy * adx;
      prod[4] <= d_bsx_asx * bdy;
      prod[5] <= d_bsy_asy * bdx;
      prod[6] <= d_aex_bsx * bdy;
      prod[7] <= d_aey_bsy * bdx;
      s1_adx  <= adx;
      s1_ady  <= ady;
      s1_asx  <= seg.a_start_x;
      s1_asy  <= seg.a_start_y;
    end
  end

  // Stage two: side tests of B against A (v1, v2) and of A against B (m1, m2).
  logic signed [sip_pkg::CPW-1:0] v1, v2, m1, m2;
  logic signed [sip_pkg::DW-1:0]  s2_adx, s2_ady;
  sip_pkg::coord_t                s2_asx, s2_asy;

  always_ff @(posedge clk) begin
    if (rst) begin
      st2_valid <= 1'b0;
    end else if (rdy2) begin
      st2_valid <= st1_valid;
    end
    if (rdy2) begin
      v1     <= sip_pkg::CPW'(prod[0]) - sip_pkg::CPW'(prod[1]);
      v2     <= sip_pkg::CPW'(prod[2]) - sip_pkg::CPW'(prod[3]);
      m1     <= sip_pkg::CPW'(prod[5]) - sip_pkg::CPW'(prod[4]);
      m2     <= sip_pkg::CPW'(prod[6]) - sip_pkg::CPW'(prod[7]);
      s2_adx <= s1_adx;
      s2_ady <= s1_ady;
      s2_asx <= s1_asx;
      s2_asy <= s1_asy;
    end
  end

  // Stage three: crossing decision and denominator. is1 equals -m1 and is2 equals m2.
  logic v_same, m_same;
  logic signed [sip_pkg::DENW-1:0] den;

  assign v_same = (!v1[sip_pkg::CPW-1] && (v1 != '0) && !v2[sip_pkg::CPW-1] && (v2 != '0)) ||
                  (v1[sip_pkg::CPW-1] && v2[sip_pkg::CPW-1]);
  assign m_same = (!m1[sip_pkg::CPW-1] && (m1 != '0) && !m2[sip_pkg::CPW-1] && (m2 != '0)) ||
                  (m1[sip_pkg::CPW-1] && m2[sip_pkg::CPW-1]);
  assign den    = sip_pkg::DENW'(m2) - sip_pkg::DENW'(m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      st3_valid <= 1'b0;
    end else if (rdy3) begin
      st3_valid <= st2_valid;
    end
    if (rdy3) begin
      out_data.hit <= !v_same && !m_same && (den != '0);
      out_data.den <= den;
      out_data.is1 <= -m1;
      out_data.adx <= s2_adx;
      out_data.ady <= s2_ady;
      out_data.asx <= s2_asx;
      out_data.asy <= s2_asy;
    end
  end

  // A denominator of zero never reaches the divider as a crossing.
  a_no_zero_den: assert property (@(posedge clk) disable iff (rst)
    st3_valid && out_data.hit |-> out_data.den != '0)
    else $error("crossing flagged with zero denominator");

endmodule
`default_nettype wire

// ===== rtl/sip_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sip_scale (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire sip_pkg::geom_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output sip_pkg::div_t       out_data
);

  logic st4_valid, st5_valid, st6_valid;
  logic rdy4, rdy5, rdy6;

  assign rdy6      = !st6_valid || out_ready;
  assign rdy5      = !st5_valid || rdy6;
  assign rdy4      = !st4_valid || rdy5;
  assign in_ready  = rdy4;
  assign out_valid = st6_valid;

  // Stage four: numerators delta * is1 for both axes.
  logic signed [sip_pkg::NW-1:0]   nx, ny;
  logic signed [sip_pkg::DENW-1:0] s4_den;
  logic                            s4_hit;
  sip_pkg::coord_t                 s4_asx, s4_asy;

  always_ff @(posedge clk) begin
    if (rst) begin
      st4_valid <= 1'b0;
    end else if (rdy4) begin
      st4_valid <= in_valid;
    end
    if (rdy4) begin
      nx     <= in_data.adx * in_data.is1;
      ny     <= in_data.ady * in_data.is1;
      s4_den <= in_data.den;
      s4_hit <= in_data.hit;
      s4_asx <= in_data.asx;
      s4_asy <= in_data.asy;
    end
  end

  // Stage five: magnitudes, with the sign of the quotient taken apart.
  logic                   s5_negx, s5_negy, s5_hit;
  logic [sip_pkg::NW-1:0]   s5_nx, s5_ny;
  logic [sip_pkg::DENW-1:0] s5_d;
  sip_pkg::coord_t        s5_asx, s5_asy;

  always_ff @(posedge clk) begin
    if (rst) begin
      st5_valid <= 1'b0;
    end else if (rdy5) begin
      st5_valid <= st4_valid;
    end
    if (rdy5) begin
      s5_negx <= (nx[sip_pkg::NW-1] ^ s4_den[sip_pkg::DENW-1]) && (nx != '0);
      s5_negy <= (ny[sip_pkg::NW-1] ^ s4_den[sip_pkg::DENW-1]) && (ny != '0);
      s5_nx   <= nx[sip_pkg::NW-1] ? sip_pkg::NW'(-nx) : sip_pkg::NW'(nx);
      s5_ny   <= ny[sip_pkg::NW-1] ? sip_pkg::NW'(-ny) : sip_pkg::NW'(ny);
      s5_d    <= s4_den[sip_pkg::DENW-1] ? sip_pkg::DENW'(-s4_den) : sip_pkg::DENW'(s4_den);
      s5_hit  <= s4_hit;
      s5_asx  <= s4_asx;
      s5_asy  <= s4_asy;
    end
  end

  // Stage six: rounding folded into numerator and divisor.
  // Non-negative: floor((2n + d) / 2d). Negative: -floor((1000n + d - 1) / 1000d).
  logic [sip_pkg::UW-1:0] ux_pos, uy_pos, ux_neg, uy_neg, v_pos, v_neg;

  assign ux_pos = sip_pkg::UW'({s5_nx, 1'b0}) + sip_pkg::UW'(s5_d);
  assign uy_pos = sip_pkg::UW'({s5_ny, 1'b0}) + sip_pkg::UW'(s5_d);
  assign ux_neg = sip_pkg::UW'(sip_pkg::UW'(s5_nx) * sip_pkg::ScaleNeg)
                  + sip_pkg::UW'(s5_d) - sip_pkg::UW'(1);
  assign uy_neg = sip_pkg::UW'(sip_pkg::UW'(s5_ny) * sip_pkg::ScaleNeg)
                  + sip_pkg::UW'(s5_d) - sip_pkg::UW'(1);
  assign v_pos  = sip_pkg::UW'({s5_d, 1'b0});
  assign v_neg  = sip_pkg::UW'(sip_pkg::UW'(s5_d) * sip_pkg::ScaleNeg);

  always_ff @(posedge clk) begin
    if (rst) begin
      st6_valid <= 1'b0;
    end else if (rdy6) begin
      st6_valid <= st5_valid;
    end
    if (rdy6) begin
      out_data.hit   <= s5_hit;
      out_data.asx   <= s5_asx;
      out_data.asy   <= s5_asy;
      out_data.x.neg <= s5_negx;
      out_data.x.rem <= s5_negx ? ux_neg : ux_pos;
      out_data.x.dvs <= s5_negx ? v_neg : v_pos;
      out_data.x.quo <= '0;
      out_data.y.neg <= s5_negy;
      out_data.y.rem <= s5_negy ? uy_neg : uy_pos;
      out_data.y.dvs <= s5_negy ? v_neg : v_pos;
      out_data.y.quo <= '0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sip_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sip_div (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sip_pkg::div_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sip_pkg::div_t      out_data
);

  localparam int NS = sip_pkg::QW;

  // Entry k + 1 is the register after the stage that settles quotient bit NS-1-k.
  sip_pkg::div_t pipe  [NS+1];
  logic          vld   [NS+1];
  logic          rdy   [NS+1];

  assign pipe[0]   = in_data;
  assign vld[0]    = in_valid;
  assign in_ready  = rdy[0];
  assign out_data  = pipe[NS];
  assign out_valid = vld[NS];
  assign rdy[NS]   = out_ready;

  // One restoring step per stage on both lanes.
  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int Bit = NS - 1 - k;
    logic [sip_pkg::UW-1:0] trial_x, trial_y;
    sip_pkg::div_t          nxt;

    assign trial_x = pipe[k].x.dvs << Bit;
    assign trial_y = pipe[k].y.dvs << Bit;
    assign rdy[k]  = !vld[k+1] || rdy[k+1];

    always_comb begin
      nxt = pipe[k];
      if (pipe[k].x.rem >= trial_x) begin
        nxt.x.rem      = pipe[k].x.rem - trial_x;
        nxt.x.quo[Bit] = 1'b1;
      end
      if (pipe[k].y.rem >= trial_y) begin
        nxt.y.rem      = pipe[k].y.rem - trial_y;
        nxt.y.quo[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k+1] <= vld[k];
      end
      if (rdy[k]) begin
        pipe[k+1] <= nxt;
      end
    end
  end

  // On a crossing the quotient fits, so the final remainder is below the divisor.
  a_rem_x: assert property (@(posedge clk) disable iff (rst)
    vld[NS] && pipe[NS].hit |-> pipe[NS].x.rem < pipe[NS].x.dvs)
    else $error("x remainder not reduced");
  a_rem_y: assert property (@(posedge clk) disable iff (rst)
    vld[NS] && pipe[NS].hit |-> pipe[NS].y.rem < pipe[NS].y.dvs)
    else $error("y remainder not reduced");

endmodule
`default_nettype wire

// ===== rtl/segment_intersection_point_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted segment pair passes through three cross-product stages, three
// scaling stages, 13 restoring divider stages that each settle one quotient
// bit, and the output register. Throughput: one pair per cycle, unless a low
// res.ready holds a full output register and back-pressure stalls the stages.
// Reset (synchronous, active high) empties every stage; no other state is kept.
module segment_intersection_point_unit (
  input  wire logic clk,
  input  wire logic rst,
  sip_in_if.sink    seg,
  sip_out_if.source res
);

  logic           g_valid, g_ready, s_valid, s_ready, d_valid, d_ready;
  sip_pkg::geom_t g_data;
  sip_pkg::div_t  s_data, d_data;

  sip_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .seg       (seg),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .out_data  (g_data)
  );

  sip_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .in_data   (g_data),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_data  (s_data)
  );

  sip_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_data   (s_data),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_data  (d_data)
  );

  // Apply the sign to each offset, add it to A's start point and clamp.
  logic signed [sip_pkg::SW-1:0] off_x, off_y, sum_x, sum_y;
  sip_pkg::coord_t               px, py;

  assign off_x = d_data.x.neg ? -$signed({1'b0, d_data.x.quo}) : $signed({1'b0, d_data.x.quo});
  assign off_y = d_data.y.neg ? -$signed({1'b0, d_data.y.quo}) : $signed({1'b0, d_data.y.quo});
  assign sum_x = $signed({2'b00, d_data.asx}) + off_x;
  assign sum_y = $signed({2'b00, d_data.asy}) + off_y;

  always_comb begin
    if (sum_x[sip_pkg::SW-1]) begin
      px = '0;
    end else if (sum_x[sip_pkg::SW-2:sip_pkg::CoordWidth] != '0) begin
      px = '1;
    end else begin
      px = sum_x[sip_pkg::CoordWidth-1:0];
    end
    if (sum_y[sip_pkg::SW-1]) begin
      py = '0;
    end else if (sum_y[sip_pkg::SW-2:sip_pkg::CoordWidth] != '0) begin
      py = '1;
    end else begin
      py = sum_y[sip_pkg::CoordWidth-1:0];
    end
  end

  // Output register; a miss gives a zero point.
  assign d_ready = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (d_ready) begin
      res.valid <= d_valid;
    end
    if (d_ready) begin
      res.crosses <= d_data.hit;
      res.cross_x <= d_data.hit ? px : '0;
      res.cross_y <= d_data.hit ? py : '0;
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.crosses |-> res.cross_x == '0 && res.cross_y == '0)
    else $error("miss beat carries a non-zero point");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res.valid)
    else $error("result beat present after reset");

endmodule
`default_nettype wire
